// ===== src/jsu_pkg.sv =====
// jsu_pkg: shared types, codes and step functions for the json5 string unescaper
// used by jsu_decode, jsu_result_buf and json5_string_unescape_unit
// no dependencies
`default_nettype none

package jsu_pkg;

  // item kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_OPEN = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // result types
  localparam logic [1:0] RES_BYTE   = 2'd0;
  localparam logic [1:0] RES_CLOSED = 2'd1;
  localparam logic [1:0] RES_ERROR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_UNTERM    = 3'd0;
  localparam logic [2:0] ERR_RAW_LB    = 3'd1;
  localparam logic [2:0] ERR_ESC_END   = 3'd2;
  localparam logic [2:0] ERR_NUL_DIGIT = 3'd3;
  localparam logic [2:0] ERR_BAD_HEX   = 3'd4;
  localparam logic [2:0] ERR_BAD_LOW   = 3'd5;
  localparam logic [2:0] ERR_NUMERIC   = 3'd6;

  // decoder modes
  localparam logic [3:0] M_IDLE     = 4'd0;
  localparam logic [3:0] M_STR      = 4'd1;
  localparam logic [3:0] M_ESC      = 4'd2;
  localparam logic [3:0] M_ESC_CR   = 4'd3;
  localparam logic [3:0] M_ESC_E2   = 4'd4;
  localparam logic [3:0] M_ESC_E280 = 4'd5;
  localparam logic [3:0] M_NUL      = 4'd6;
  localparam logic [3:0] M_HEX_X    = 4'd7;
  localparam logic [3:0] M_HEX_U    = 4'd8;
  localparam logic [3:0] M_HI       = 4'd9;
  localparam logic [3:0] M_HI_BS    = 4'd10;
  localparam logic [3:0] M_HEX_LOW  = 4'd11;

  localparam int MAX_RES = 4;
  localparam int IDX_W   = $clog2(MAX_RES);
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  typedef struct packed {
    logic [1:0] result_type;
    logic [7:0] out_byte;
    logic [2:0] error_code;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] items;
    logic [CNT_W-1:0]   cnt;
  } res_set_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic        quote_is_single;
    logic [15:0] hex_acc;
    logic [2:0]  hex_left;
    logic [9:0]  pend_hi;
  } state_t;

  typedef struct packed {
    state_t   st;
    res_set_t rs;
  } step_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic step_t push(step_t x, logic [1:0] t, logic [7:0] b, logic [2:0] e);
    if (x.rs.cnt < CNT_W'(MAX_RES)) begin
      x.rs.items[x.rs.cnt[IDX_W-1:0]] = '{result_type: t, out_byte: b, error_code: e};
      x.rs.cnt = x.rs.cnt + CNT_W'(1);
    end
    return x;
  endfunction

  function automatic step_t emit_byte(step_t x, logic [7:0] b);
    return push(x, RES_BYTE, b, ERR_UNTERM);
  endfunction

  function automatic step_t fail(step_t x, logic [2:0] code);
    step_t y;
    y = push(x, RES_ERROR, 8'h00, code);
    y.st.mode = M_IDLE;
    return y;
  endfunction

  function automatic step_t emit_utf8(step_t x, logic [20:0] c);
    step_t y;
    y = x;
    if (c < 21'h80) begin
      y = emit_byte(y, c[7:0]);
    end else if (c < 21'h800) begin
      y = emit_byte(y, {3'b110, c[10:6]});
      y = emit_byte(y, {2'b10, c[5:0]});
    end else if (c < 21'h10000) begin
      y = emit_byte(y, {4'b1110, c[15:12]});
      y = emit_byte(y, {2'b10, c[11:6]});
      y = emit_byte(y, {2'b10, c[5:0]});
    end else begin
      y = emit_byte(y, {5'b11110, c[20:18]});
      y = emit_byte(y, {2'b10, c[17:12]});
      y = emit_byte(y, {2'b10, c[11:6]});
      y = emit_byte(y, {2'b10, c[5:0]});
    end
    return y;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b inside {[8'h30:8'h39]});
  endfunction

  function automatic hex_t hex_value(logic [7:0] b);
    hex_t h;
    logic [7:0] d;
    h = '0;
    d = 8'h00;
    if (b inside {[8'h30:8'h39]}) begin
      d = b - 8'h30;
      h = '{ok: 1'b1, val: d[3:0]};
    end else if (b inside {[8'h61:8'h66]}) begin
      d = b - 8'h57;
      h = '{ok: 1'b1, val: d[3:0]};
    end else if (b inside {[8'h41:8'h46]}) begin
      d = b - 8'h37;
      h = '{ok: 1'b1, val: d[3:0]};
    end
    return h;
  endfunction

  // lone high surrogate as a three byte sequence
  function automatic step_t lone_high(step_t x);
    return emit_utf8(x, {5'b00000, 6'b110110, x.st.pend_hi});
  endfunction

  // raw byte inside the literal
  function automatic step_t do_str(step_t x, logic [7:0] b);
    step_t y;
    logic [7:0] q;
    y = x;
    q = x.st.quote_is_single ? 8'h27 : 8'h22;
    y.st.mode = M_STR;
    if (b == q) begin
      y = push(y, RES_CLOSED, 8'h00, ERR_UNTERM);
      y.st.mode = M_IDLE;
    end else if (b == 8'h0A || b == 8'h0D) begin
      y = fail(y, ERR_RAW_LB);
    end else if (b == 8'h5C) begin
      y.st.mode = M_ESC;
    end else begin
      y = emit_byte(y, b);
    end
    return y;
  endfunction

  // byte after a backslash
  function automatic step_t do_esc(step_t x, logic [7:0] b);
    step_t y;
    y = x;
    y.st.mode = M_STR;
    case (b)
      8'h0A: ;
      8'h0D: y.st.mode = M_ESC_CR;
      8'hE2: y.st.mode = M_ESC_E2;
      8'h62: y = emit_byte(y, 8'h08);
      8'h66: y = emit_byte(y, 8'h0C);
      8'h6E: y = emit_byte(y, 8'h0A);
      8'h72: y = emit_byte(y, 8'h0D);
      8'h74: y = emit_byte(y, 8'h09);
      8'h76: y = emit_byte(y, 8'h0B);
      8'h30: y.st.mode = M_NUL;
      8'h78: begin
        y.st.mode     = M_HEX_X;
        y.st.hex_acc  = 16'h0000;
        y.st.hex_left = 3'd2;
      end
      8'h75: begin
        y.st.mode     = M_HEX_U;
        y.st.hex_acc  = 16'h0000;
        y.st.hex_left = 3'd4;
      end
      default: begin
        if (is_digit(b)) y = fail(y, ERR_NUMERIC);
        else             y = emit_byte(y, b);
      end
    endcase
    return y;
  endfunction

endpackage

`default_nettype wire

// ===== src/jsu_if.sv =====
// jsu_if: valid/ready channel interfaces for input items and result beats
// depends on nothing
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;

  modport source (output valid, kind, data_byte, input ready);
  modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_type;
  logic [7:0] out_byte;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, result_type, out_byte, error_code, last, input ready);
  modport sink   (input valid, result_type, out_byte, error_code, last, output ready);
endinterface

`default_nettype wire

// ===== src/jsu_decode.sv =====
// jsu_decode: one step of the unescaper, current state and item to next state
// and up to four result beats; uses jsu_pkg
`default_nettype none

module jsu_decode (
  input  var jsu_pkg::state_t cur,
  input  logic [1:0]          kind,
  input  logic [7:0]          data_byte,
  output jsu_pkg::step_t      nxt
);

  jsu_pkg::hex_t hv;
  logic [15:0]   acc_new;
  logic [2:0]    left_new;

  assign hv       = jsu_pkg::hex_value(data_byte);
  assign acc_new  = {cur.hex_acc[11:0], hv.val};
  assign left_new = cur.hex_left - 3'd1;

  always_comb begin
    jsu_pkg::step_t x;
    x    = '0;
    x.st = cur;
    case (kind)
      jsu_pkg::KIND_OPEN: begin
        x.st.mode            = jsu_pkg::M_STR;
        x.st.quote_is_single = (data_byte == 8'h27);
        x.st.hex_acc         = 16'h0000;
        x.st.hex_left        = 3'd0;
        x.st.pend_hi         = 10'd0;
      end
      jsu_pkg::KIND_BYTE: begin
        case (cur.mode)
          jsu_pkg::M_IDLE: ;
          jsu_pkg::M_STR: x = jsu_pkg::do_str(x, data_byte);
          jsu_pkg::M_ESC: x = jsu_pkg::do_esc(x, data_byte);
          jsu_pkg::M_ESC_CR: begin
            x.st.mode = jsu_pkg::M_STR;
            if (data_byte != 8'h0A) x = jsu_pkg::do_str(x, data_byte);
          end
          jsu_pkg::M_ESC_E2: begin
            if (data_byte == 8'h80) begin
              x.st.mode = jsu_pkg::M_ESC_E280;
            end else begin
              x = jsu_pkg::emit_byte(x, 8'hE2);
              x = jsu_pkg::do_str(x, data_byte);
            end
          end
          jsu_pkg::M_ESC_E280: begin
            if (data_byte == 8'hA8 || data_byte == 8'hA9) begin
              x.st.mode = jsu_pkg::M_STR;
            end else begin
              x = jsu_pkg::emit_byte(x, 8'hE2);
              x = jsu_pkg::do_str(x, 8'h80);
              x = jsu_pkg::do_str(x, data_byte);
            end
          end
          jsu_pkg::M_NUL: begin
            if (jsu_pkg::is_digit(data_byte)) begin
              x = jsu_pkg::fail(x, jsu_pkg::ERR_NUL_DIGIT);
            end else begin
              x = jsu_pkg::emit_byte(x, 8'h00);
              x = jsu_pkg::do_str(x, data_byte);
            end
          end
          jsu_pkg::M_HEX_X, jsu_pkg::M_HEX_U, jsu_pkg::M_HEX_LOW: begin
            if (!hv.ok) begin
              x = jsu_pkg::fail(x, jsu_pkg::ERR_BAD_HEX);
            end else begin
              x.st.hex_acc  = acc_new;
              x.st.hex_left = left_new;
              if (left_new == 3'd0) begin
                if (cur.mode == jsu_pkg::M_HEX_X) begin
                  x = jsu_pkg::emit_utf8(x, {5'b00000, acc_new});
                  x.st.mode = jsu_pkg::M_STR;
                end else if (cur.mode == jsu_pkg::M_HEX_U) begin
                  if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
                    x.st.pend_hi = acc_new[9:0];
                    x.st.mode    = jsu_pkg::M_HI;
                  end else begin
                    x = jsu_pkg::emit_utf8(x, {5'b00000, acc_new});
                    x.st.mode = jsu_pkg::M_STR;
                  end
                end else begin
                  if (acc_new < 16'hDC00 || acc_new > 16'hDFFF) begin
                    x = jsu_pkg::fail(x, jsu_pkg::ERR_BAD_LOW);
                  end else begin
                    x = jsu_pkg::emit_utf8(x,
                          21'h10000 + {1'b0, cur.pend_hi, acc_new[9:0]});
                    x.st.mode = jsu_pkg::M_STR;
                  end
                end
              end
            end
          end
          jsu_pkg::M_HI: begin
            if (data_byte == 8'h5C) begin
              x.st.mode = jsu_pkg::M_HI_BS;
            end else begin
              x = jsu_pkg::lone_high(x);
              x = jsu_pkg::do_str(x, data_byte);
            end
          end
          jsu_pkg::M_HI_BS: begin
            if (data_byte == 8'h75) begin
              x.st.mode     = jsu_pkg::M_HEX_LOW;
              x.st.hex_acc  = 16'h0000;
              x.st.hex_left = 3'd4;
            end else begin
              x = jsu_pkg::lone_high(x);
              x = jsu_pkg::do_esc(x, data_byte);
            end
          end
          default: x.st.mode = jsu_pkg::M_IDLE;
        endcase
      end
      jsu_pkg::KIND_END: begin
        case (cur.mode)
          jsu_pkg::M_IDLE: ;
          jsu_pkg::M_STR, jsu_pkg::M_ESC_CR: x = jsu_pkg::fail(x, jsu_pkg::ERR_UNTERM);
          jsu_pkg::M_ESC: x = jsu_pkg::fail(x, jsu_pkg::ERR_ESC_END);
          jsu_pkg::M_ESC_E2: begin
            x = jsu_pkg::emit_byte(x, 8'hE2);
            x = jsu_pkg::fail(x, jsu_pkg::ERR_UNTERM);
          end
          jsu_pkg::M_ESC_E280: begin
            x = jsu_pkg::emit_byte(x, 8'hE2);
            x = jsu_pkg::emit_byte(x, 8'h80);
            x = jsu_pkg::fail(x, jsu_pkg::ERR_UNTERM);
          end
          jsu_pkg::M_NUL: begin
            x = jsu_pkg::emit_byte(x, 8'h00);
            x = jsu_pkg::fail(x, jsu_pkg::ERR_UNTERM);
          end
          jsu_pkg::M_HEX_X, jsu_pkg::M_HEX_U, jsu_pkg::M_HEX_LOW:
            x = jsu_pkg::fail(x, jsu_pkg::ERR_BAD_HEX);
          jsu_pkg::M_HI: begin
            x = jsu_pkg::lone_high(x);
            x = jsu_pkg::fail(x, jsu_pkg::ERR_UNTERM);
          end
          jsu_pkg::M_HI_BS: begin
            x = jsu_pkg::lone_high(x);
            x = jsu_pkg::fail(x, jsu_pkg::ERR_ESC_END);
          end
          default: x.st.mode = jsu_pkg::M_IDLE;
        endcase
      end
      default: ;
    endcase
    nxt = x;
  end

endmodule

`default_nettype wire

// ===== src/jsu_result_buf.sv =====
// jsu_result_buf: result register holding the beats of one item, sent one a cycle while res.ready is high
// uses jsu_pkg and jsu_out_if
`default_nettype none

module jsu_result_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  var jsu_pkg::res_set_t set_in,
  output logic                  free,
  jsu_out_if.source             res
);

  jsu_pkg::res_t [jsu_pkg::MAX_RES-1:0] items;
  logic [jsu_pkg::CNT_W-1:0]            rem;
  logic [jsu_pkg::IDX_W-1:0]            idx;
  logic                                 take;

  assign take = res.valid && res.ready;
  assign free = (rem == '0) || (rem == jsu_pkg::CNT_W'(1) && res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      idx <= '0;
    end else if (load) begin
      rem <= set_in.cnt;
      idx <= '0;
    end else if (take) begin
      rem <= rem - jsu_pkg::CNT_W'(1);
      idx <= idx + jsu_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      items <= set_in.items;
    end
  end

  assign res.valid       = (rem != '0);
  assign res.result_type = items[idx].result_type;
  assign res.out_byte    = items[idx].out_byte;
  assign res.error_code  = items[idx].error_code;
  assign res.last        = (rem == jsu_pkg::CNT_W'(1));

endmodule

`default_nettype wire

// ===== src/json5_string_unescape_unit.sv =====
// json5_string_unescape_unit: top level of the json5 string literal unescaper
// uses jsu_pkg, jsu_if, jsu_decode and jsu_result_buf
//
//   channel      dir  payload                                         beat
//   byte_stream  in   kind[1:0] data_byte[7:0]                       one text byte
//   decoded      out  result_type[1:0] out_byte[7:0] error_code[2:0]  one result
//                     last
//
// an item is taken into the input register, decoded from it and its results written to
// the result register once that is free; the first beat is sent from the result register
// one item per cycle when each gives at most one result and decoded is ready; an item
// with several results holds the input register while the result register drains
// rst (synchronous) closes any open literal and empties the result register
// a stall on decoded backs up through the input register into byte_stream.ready
`default_nettype none

module json5_string_unescape_unit (
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    byte_stream,
  jsu_out_if.source decoded
);

  logic            item_valid;
  logic [1:0]      item_kind;
  logic [7:0]      item_data;
  logic            advance;
  logic            buf_free;
  jsu_pkg::state_t st;
  jsu_pkg::step_t  nxt;

  assign advance           = item_valid && buf_free;
  assign byte_stream.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (byte_stream.ready) begin
      item_valid <= byte_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_stream.valid && byte_stream.ready) begin
      item_kind <= byte_stream.kind;
      item_data <= byte_stream.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{mode: jsu_pkg::M_IDLE, quote_is_single: 1'b0, hex_acc: 16'h0000,
              hex_left: 3'd0, pend_hi: 10'd0};
    end else if (advance) begin
      st <= nxt.st;
    end
  end

  jsu_decode u_decode (
    .cur       (st),
    .kind      (item_kind),
    .data_byte (item_data),
    .nxt       (nxt)
  );

  jsu_result_buf u_result_buf (
    .clk    (clk),
    .rst    (rst),
    .load   (advance),
    .set_in (nxt.rs),
    .free   (buf_free),
    .res    (decoded)
  );

  // a closed or error result always ends its item
  a_term_is_last: assert property (@(posedge clk) disable iff (rst)
    decoded.valid && (decoded.result_type != jsu_pkg::RES_BYTE) |-> decoded.last)
    else $error("closed or error beat not marked last");

  // beats of one item come out back to back
  a_beats_contiguous: assert property (@(posedge clk) disable iff (rst)
    decoded.valid && decoded.ready && !decoded.last |=> decoded.valid)
    else $error("gap inside the beats of one item");

  // a held item stays put until the result register takes it
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    item_valid && !advance |=> item_valid && $stable(item_kind) && $stable(item_data))
    else $error("input register lost a waiting item");

endmodule

`default_nettype wire

// ===== test/jsu_unescape_checker.sv =====
// jsu_unescape_checker: watches byte_stream and decoded, predicts the decoded beats
// of every accepted item and compares them in order, counting mismatches
// depends on jsu_pkg and jsu_if
`timescale 1ns / 1ps

module jsu_unescape_checker (
  input  logic clk,
  input  logic rst,
  jsu_in_if    byte_stream,
  jsu_out_if   decoded,
  output int   fails,
  output int   pending
);
  import jsu_pkg::*;

  localparam logic [2:0] NO_ERR = 3'd0;

  typedef struct {
    logic [1:0] rtype;
    logic [7:0] ch;
    logic [2:0] err;
    logic       last;
  } beat_t;

  beat_t expected_beats[$];
  beat_t item_beats[$];
  beat_t want;

  logic [3:0]  lit_mode    = M_IDLE;
  logic        single_q    = 1'b0;
  logic [15:0] hex_acc     = 16'h0000;
  logic [2:0]  digits_left = 3'd0;
  logic [9:0]  hi_half     = 10'd0;

  initial begin
    fails   = 0;
    pending = 0;
  end

  task automatic add_beat(input logic [1:0] t, input logic [7:0] c, input logic [2:0] e);
    beat_t b;
    b = '{rtype: t, ch: c, err: e, last: 1'b0};
    if (item_beats.size() < MAX_RES) item_beats = {item_beats, b};
  endtask

  task automatic add_code(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_beat(RES_BYTE, cp[7:0], NO_ERR);
    end else if (cp < 21'h800) begin
      add_beat(RES_BYTE, {3'b110, cp[10:6]}, NO_ERR);
      add_beat(RES_BYTE, {2'b10, cp[5:0]}, NO_ERR);
    end else if (cp < 21'h10000) begin
      add_beat(RES_BYTE, {4'b1110, cp[15:12]}, NO_ERR);
      add_beat(RES_BYTE, {2'b10, cp[11:6]}, NO_ERR);
      add_beat(RES_BYTE, {2'b10, cp[5:0]}, NO_ERR);
    end else begin
      add_beat(RES_BYTE, {5'b11110, cp[20:18]}, NO_ERR);
      add_beat(RES_BYTE, {2'b10, cp[17:12]}, NO_ERR);
      add_beat(RES_BYTE, {2'b10, cp[11:6]}, NO_ERR);
      add_beat(RES_BYTE, {2'b10, cp[5:0]}, NO_ERR);
    end
  endtask

  task automatic abort_literal(input logic [2:0] code);
    add_beat(RES_ERROR, 8'h00, code);
    lit_mode = M_IDLE;
  endtask

  task automatic lone_high_out();
    add_code(21'h0D800 + 21'(hi_half));
  endtask

  task automatic str_char(input logic [7:0] b);
    lit_mode = M_STR;
    if (b == (single_q ? 8'h27 : 8'h22)) begin
      add_beat(RES_CLOSED, 8'h00, NO_ERR);
      lit_mode = M_IDLE;
    end else if (b == 8'h0A || b == 8'h0D) begin
      abort_literal(ERR_RAW_LB);
    end else if (b == 8'h5C) begin
      lit_mode = M_ESC;
    end else begin
      add_beat(RES_BYTE, b, NO_ERR);
    end
  endtask

  task automatic esc_char(input logic [7:0] b);
    lit_mode = M_STR;
    case (b)
      8'h0A: ;
      8'h0D: lit_mode = M_ESC_CR;
      8'hE2: lit_mode = M_ESC_E2;
      8'h62: add_beat(RES_BYTE, 8'h08, NO_ERR);
      8'h66: add_beat(RES_BYTE, 8'h0C, NO_ERR);
      8'h6E: add_beat(RES_BYTE, 8'h0A, NO_ERR);
      8'h72: add_beat(RES_BYTE, 8'h0D, NO_ERR);
      8'h74: add_beat(RES_BYTE, 8'h09, NO_ERR);
      8'h76: add_beat(RES_BYTE, 8'h0B, NO_ERR);
      8'h30: lit_mode = M_NUL;
      8'h78: begin
        lit_mode    = M_HEX_X;
        hex_acc     = 16'h0000;
        digits_left = 3'd2;
      end
      8'h75: begin
        lit_mode    = M_HEX_U;
        hex_acc     = 16'h0000;
        digits_left = 3'd4;
      end
      default: begin
        if (b >= 8'h31 && b <= 8'h39) abort_literal(ERR_NUMERIC);
        else add_beat(RES_BYTE, b, NO_ERR);
      end
    endcase
  endtask

  task automatic hex_step(input logic [7:0] b, output logic done);
    logic [3:0] nib;
    logic       ok;
    nib  = 4'd0;
    ok   = 1'b1;
    done = 1'b0;
    if (b >= 8'h30 && b <= 8'h39) nib = b[3:0];
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) nib = b[3:0] + 4'd9;
    else ok = 1'b0;
    if (!ok) begin
      abort_literal(ERR_BAD_HEX);
    end else begin
      hex_acc     = {hex_acc[11:0], nib};
      digits_left = digits_left - 3'd1;
      done        = (digits_left == 3'd0);
    end
  endtask

  task automatic raw_in(input logic [7:0] b);
    logic done;
    done = 1'b0;
    case (lit_mode)
      M_STR: str_char(b);
      M_ESC: esc_char(b);
      M_ESC_CR: begin
        lit_mode = M_STR;
        if (b != 8'h0A) str_char(b);
      end
      M_ESC_E2: begin
        if (b == 8'h80) begin
          lit_mode = M_ESC_E280;
        end else begin
          add_beat(RES_BYTE, 8'hE2, NO_ERR);
          str_char(b);
        end
      end
      M_ESC_E280: begin
        if (b == 8'hA8 || b == 8'hA9) begin
          lit_mode = M_STR;
        end else begin
          add_beat(RES_BYTE, 8'hE2, NO_ERR);
          str_char(8'h80);
          str_char(b);
        end
      end
      M_NUL: begin
        if (b >= 8'h30 && b <= 8'h39) begin
          abort_literal(ERR_NUL_DIGIT);
        end else begin
          add_beat(RES_BYTE, 8'h00, NO_ERR);
          str_char(b);
        end
      end
      M_HEX_X: begin
        hex_step(b, done);
        if (done) begin
          add_code(21'(hex_acc));
          lit_mode = M_STR;
        end
      end
      M_HEX_U: begin
        hex_step(b, done);
        if (done) begin
          if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
            hi_half  = hex_acc[9:0];
            lit_mode = M_HI;
          end else begin
            add_code(21'(hex_acc));
            lit_mode = M_STR;
          end
        end
      end
      M_HI: begin
        if (b == 8'h5C) begin
          lit_mode = M_HI_BS;
        end else begin
          lone_high_out();
          str_char(b);
        end
      end
      M_HI_BS: begin
        if (b == 8'h75) begin
          lit_mode    = M_HEX_LOW;
          hex_acc     = 16'h0000;
          digits_left = 3'd4;
        end else begin
          lone_high_out();
          esc_char(b);
        end
      end
      M_HEX_LOW: begin
        hex_step(b, done);
        if (done) begin
          if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
            abort_literal(ERR_BAD_LOW);
          end else begin
            add_code(21'h10000 + {1'b0, hi_half, hex_acc[9:0]});
            lit_mode = M_STR;
          end
        end
      end
      default: lit_mode = M_IDLE;
    endcase
  endtask

  task automatic end_in();
    case (lit_mode)
      M_STR, M_ESC_CR: abort_literal(ERR_UNTERM);
      M_ESC: abort_literal(ERR_ESC_END);
      M_ESC_E2: begin
        add_beat(RES_BYTE, 8'hE2, NO_ERR);
        abort_literal(ERR_UNTERM);
      end
      M_ESC_E280: begin
        add_beat(RES_BYTE, 8'hE2, NO_ERR);
        add_beat(RES_BYTE, 8'h80, NO_ERR);
        abort_literal(ERR_UNTERM);
      end
      M_NUL: begin
        add_beat(RES_BYTE, 8'h00, NO_ERR);
        abort_literal(ERR_UNTERM);
      end
      M_HEX_X, M_HEX_U, M_HEX_LOW: abort_literal(ERR_BAD_HEX);
      M_HI: begin
        lone_high_out();
        abort_literal(ERR_UNTERM);
      end
      M_HI_BS: begin
        lone_high_out();
        abort_literal(ERR_ESC_END);
      end
      default: lit_mode = M_IDLE;
    endcase
  endtask

  task automatic predict_item(input logic [1:0] k, input logic [7:0] b);
    item_beats.delete();
    case (k)
      KIND_OPEN: begin
        single_q    = (b == 8'h27);
        hex_acc     = 16'h0000;
        digits_left = 3'd0;
        hi_half     = 10'd0;
        lit_mode    = M_STR;
      end
      KIND_BYTE: if (lit_mode != M_IDLE) raw_in(b);
      KIND_END:  if (lit_mode != M_IDLE) end_in();
      default: ;
    endcase
    if (item_beats.size() > 0) item_beats[item_beats.size() - 1].last = 1'b1;
    expected_beats = {expected_beats, item_beats};
  endtask

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      lit_mode    = M_IDLE;
      single_q    = 1'b0;
      hex_acc     = 16'h0000;
      digits_left = 3'd0;
      hi_half     = 10'd0;
      expected_beats.delete();
    end else begin
      if (byte_stream.valid && byte_stream.ready)
        predict_item(byte_stream.kind, byte_stream.data_byte);
      if (decoded.valid && decoded.ready) begin
        if (expected_beats.size() == 0) begin
          $error("decoded beat with none expected: result_type %0d out_byte %0h error_code %0d",
                 decoded.result_type, decoded.out_byte, decoded.error_code);
          fails++;
        end else begin
          want = expected_beats.pop_front();
          check_field("result_type", 8'(want.rtype), 8'(decoded.result_type));
          check_field("out_byte", want.ch, decoded.out_byte);
          check_field("error_code", 8'(want.err), 8'(decoded.error_code));
          check_field("last", 8'(want.last), 8'(decoded.last));
        end
      end
    end
    pending = expected_beats.size();
  end

endmodule

// ===== test/tb_json5_string_unescape_unit.sv =====
// tb_json5_string_unescape_unit: feeds directed and random json5 string literals into
// the unescaper with random gaps and output stalls, verdict from the checker's count
// depends on jsu_pkg, jsu_if, jsu_unescape_checker and json5_string_unescape_unit
`timescale 1ns / 1ps

module tb_json5_string_unescape_unit;
  import jsu_pkg::*;

  localparam logic [1:0] KIND_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT  = 500000;
  localparam int         TARGET_ITEMS = 220;

  logic clk  = 1'b0;
  logic rst  = 1'b1;
  logic calm = 1'b0;
  int   fails;
  int   pending;
  int   stall_left = 0;
  int   stall_pick;
  int   cycles = 0;
  int   sent = 0;
  int   lits = 0;

  jsu_in_if  byte_stream ();
  jsu_out_if decoded ();

  json5_string_unescape_unit dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .decoded     (decoded)
  );

  jsu_unescape_checker chk (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .decoded     (decoded),
    .fails       (fails),
    .pending     (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // output stalls, mostly short, none while calm
  always @(posedge clk) begin
    if (rst || calm) begin
      stall_left    <= 0;
      decoded.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      decoded.ready <= 1'b0;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 65) begin
        decoded.ready <= 1'b1;
      end else begin
        decoded.ready <= 1'b0;
        stall_left    <= (stall_pick < 95) ? $urandom_range(0, 2) : $urandom_range(5, 25);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic put_item(input logic [1:0] k, input logic [7:0] b);
    int   gap;
    logic took;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      byte_stream.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_stream.valid     <= 1'b1;
    byte_stream.kind      <= k;
    byte_stream.data_byte <= b;
    do begin
      @(negedge clk);
      took = byte_stream.ready;
      @(posedge clk);
    end while (!took);
    sent++;
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_item(KIND_BYTE, s[i]);
  endtask

  task automatic wait_drain();
    byte_stream.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  task automatic put_hex(input logic [15:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) put_item(KIND_BYTE, hex_char(v[4*i +: 4]));
  endtask

  function automatic logic [7:0] plain_char(input logic [7:0] q);
    logic [7:0] b;
    b = 8'($urandom);
    if ($urandom_range(0, 49) == 0) return b;
    while (b == q || b == 8'h5C || b == 8'h0A || b == 8'h0D) b = 8'($urandom);
    return b;
  endfunction

  function automatic logic [7:0] esc_pick();
    string      named_esc;
    logic [7:0] b;
    named_esc = "bfnrtv'\"\\";
    if ($urandom_range(0, 1) == 0) return named_esc[$urandom_range(0, named_esc.len() - 1)];
    do b = 8'($urandom);
    while ((b >= 8'h30 && b <= 8'h39) || b == 8'h78 || b == 8'h75 || b == 8'h0D ||
           b == 8'hE2);
    return b;
  endfunction

  function automatic logic [7:0] bad_hex_char();
    string s;
    s = "gG/:@`zZ \"";
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic put_high();
    put_str("\\u");
    put_hex(16'hD800 | 16'($urandom_range(0, 1023)), 4);
  endtask

  // mostly well-formed piece of literal content
  task automatic put_segment(input logic [7:0] q);
    int          r;
    logic [15:0] v;
    r = $urandom_range(0, 15);
    v = 16'($urandom);
    case (r)
      0, 1, 2, 3, 4, 15: put_item(KIND_BYTE, plain_char(q));
      5: begin
        put_str("\\");
        put_item(KIND_BYTE, esc_pick());
      end
      6: begin
        put_str("\\0");
        put_item(KIND_BYTE, plain_char(q));
      end
      7: begin
        put_str("\\x");
        put_hex(v, 2);
      end
      8: begin
        put_str("\\u");
        put_hex(v, 4);
      end
      9, 10: begin
        put_high();
        put_str("\\u");
        put_hex(16'hDC00 | 16'($urandom_range(0, 1023)), 4);
      end
      11: begin
        put_high();
        if ($urandom_range(0, 1) == 1) begin
          put_str("\\");
          put_item(KIND_BYTE, esc_pick());
        end
      end
      12: begin
        put_str("\\");
        case ($urandom_range(0, 2))
          0: put_item(KIND_BYTE, 8'h0A);
          1: put_item(KIND_BYTE, 8'h0D);
          default: begin
            put_item(KIND_BYTE, 8'h0D);
            put_item(KIND_BYTE, 8'h0A);
          end
        endcase
      end
      13: begin
        put_str("\\");
        put_item(KIND_BYTE, 8'hE2);
        put_item(KIND_BYTE, 8'h80);
        put_item(KIND_BYTE, ($urandom_range(0, 1) == 1) ? 8'hA8 : 8'hA9);
      end
      default: begin
        put_str("\\");
        case ($urandom_range(0, 2))
          0: put_item(KIND_BYTE, 8'h0D);
          1: put_item(KIND_BYTE, 8'hE2);
          default: begin
            put_item(KIND_BYTE, 8'hE2);
            put_item(KIND_BYTE, 8'h80);
          end
        endcase
        put_item(KIND_BYTE, plain_char(q));
      end
    endcase
  endtask

  // literal cut short by end of text
  task automatic put_dangling_end();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 9))
      0: ;
      1: put_str("\\");
      2: begin
        if ($urandom_range(0, 1) == 1) begin
          put_str("\\x");
          put_hex(v, $urandom_range(0, 1));
        end else begin
          put_str("\\u");
          put_hex(v, $urandom_range(0, 3));
        end
      end
      3: put_str("\\0");
      4: begin
        put_str("\\");
        put_item(KIND_BYTE, 8'hE2);
      end
      5: begin
        put_str("\\");
        put_item(KIND_BYTE, 8'hE2);
        put_item(KIND_BYTE, 8'h80);
      end
      6: begin
        put_str("\\");
        put_item(KIND_BYTE, 8'h0D);
      end
      7: put_high();
      8: begin
        put_high();
        put_str("\\");
      end
      default: begin
        put_high();
        put_str("\\u");
        put_hex(v, 2);
      end
    endcase
    put_item(KIND_END, 8'($urandom));
  endtask

  task automatic put_fault();
    logic [15:0] lo;
    case ($urandom_range(0, 4))
      0: put_item(KIND_BYTE, ($urandom_range(0, 1) == 1) ? 8'h0A : 8'h0D);
      1: begin
        put_str("\\");
        put_item(KIND_BYTE, 8'($urandom_range('h31, 'h39)));
      end
      2: begin
        put_str("\\0");
        put_item(KIND_BYTE, 8'($urandom_range('h30, 'h39)));
      end
      3: begin
        if ($urandom_range(0, 1) == 1) begin
          put_str("\\x");
          put_hex(16'($urandom), $urandom_range(0, 1));
        end else begin
          put_str("\\u");
          put_hex(16'($urandom), $urandom_range(0, 3));
        end
        put_item(KIND_BYTE, bad_hex_char());
      end
      default: begin
        put_high();
        put_str("\\u");
        do lo = 16'($urandom); while (lo[15:10] == 6'b110111);
        put_hex(lo, 4);
      end
    endcase
  endtask

  task automatic put_literal();
    int         r;
    int         n;
    logic [7:0] ob;
    logic [7:0] q;
    calm <= ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 3)) put_item(2'($urandom), 8'($urandom));
    end
    r  = $urandom_range(0, 19);
    ob = (r < 9) ? 8'h27 : (r < 18) ? 8'h22 : 8'($urandom);
    q  = (ob == 8'h27) ? 8'h27 : 8'h22;
    put_item(KIND_OPEN, ob);
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 5);
    repeat (n) put_segment(q);
    r = $urandom_range(0, 19);
    if (r < 13) put_item(KIND_BYTE, q);
    else if (r < 16) put_dangling_end();
    else if (r < 19) put_fault();
  endtask

  initial begin
    byte_stream.valid     = 1'b0;
    byte_stream.kind      = KIND_BYTE;
    byte_stream.data_byte = 8'h00;
    decoded.ready         = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle input, then a single-quoted literal with extremes and a surrogate pair
    put_item(KIND_BYTE, 8'h41);
    put_item(KIND_END, 8'h00);
    put_item(KIND_SPARE, 8'hFF);
    put_item(KIND_OPEN, 8'h27);
    put_item(KIND_BYTE, 8'h00);
    put_item(KIND_BYTE, 8'hFF);
    put_item(KIND_BYTE, 8'h22);
    put_str("\\uD83D\\uDE00");
    put_item(KIND_BYTE, 8'h27);
    // reopen, ignored kind while open, then end of text
    put_item(KIND_OPEN, 8'h22);
    put_item(KIND_OPEN, 8'h22);
    put_item(KIND_SPARE, 8'h00);
    put_item(KIND_END, 8'h00);
    wait_drain();

    while (sent < TARGET_ITEMS) begin
      put_literal();
      lits++;
      if (lits % 12 == 0) wait_drain();
    end
    wait_drain();
    repeat (20) @(posedge clk);

    if (fails == 0 && pending == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== json5_string_unescape_unit.f =====
src/jsu_pkg.sv
src/jsu_if.sv
src/jsu_decode.sv
src/jsu_result_buf.sv
src/json5_string_unescape_unit.sv
test/jsu_unescape_checker.sv
test/tb_json5_string_unescape_unit.sv
